// ===== rtl/core/kdsm_pkg.sv =====
// ----------------------------------------------------------------------------
// kdsm_pkg
// Shared types and constants for the kd split chooser.
// ----------------------------------------------------------------------------
package kdsm_pkg;

    localparam int CoordW = 32;
    localparam int LenW   = 31;
    localparam int M2W    = 32;
    localparam int SqInW  = 2 * M2W - 16;   // metric_len2 << 16
    localparam int RootW  = SqInW / 2;      // 24-bit metric length
    localparam int SqRemW = RootW + 2;
    localparam int LimW   = 2 * LenW;       // MR * edge
    localparam int QuoW   = LenW;           // quotient fits when len >= 2*MR
    localparam int LoW    = CoordW + 1 + RootW + 1;
    localparam int HiW    = CoordW + 2 + RootW + 1;
    localparam int InW    = 384;
    localparam int OutW   = 40;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [2:0] {
        CASE_HALF   = 3'd0,
        CASE_LOW    = 3'd1,
        CASE_HIGH   = 3'd2,
        CASE_AFTER  = 3'd3,
        CASE_BEFORE = 3'd4
    } split_case_t;

    typedef struct packed {
        axis_t                     axis;
        logic signed [CoordW-1:0]  d0;
        logic [LenW-1:0]           d10;
        logic signed [CoordW-1:0]  dp;
        logic                      too_small;
        logic [LimW-1:0]           lim;
        logic [SqInW-1:0]          sq_v;
        logic [SqRemW-1:0]         sq_rem;
        logic [RootW-1:0]          len;
        logic signed [LoW-1:0]     p_lo;
        logic signed [HiW-1:0]     p_hi;
        logic [RootW-1:0]          dv_rem;
        logic [QuoW-1:0]           dv_dd;
        logic [QuoW-1:0]           quo;
    } item_t;

endpackage

// ===== rtl/core/kd_split_min_metric_length.sv =====
// Stages from input transaction to result: 1 front, 24 root cells,
// 1 product stage, 31 divide cells, 1 output register.
// Throughput: one transaction per cycle unless stalled; the cell chains move one step a cycle.
// The whole chain halts while a result waits on m_tready.
// Reset: rst_n clears all valid bits and sets min_metric_len to 1.0.
// ----------------------------------------------------------------------------
// kd_split_min_metric_length
// Kd split axis and coordinate with a minimum metric cell length.
// ----------------------------------------------------------------------------
module kd_split_min_metric_length
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [kdsm_pkg::LenW-1:0]  cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // box_min_x/y/z, box_len_x/y/z, point_x/y/z, metric_len2_x/y/z, zero pad
    input  logic [kdsm_pkg::InW-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // chosen axis, split_coord, split_case, box_too_small, zero pad
    output logic [kdsm_pkg::OutW-1:0]  m_tdata
);
    import kdsm_pkg::*;

    localparam int NSq  = RootW;
    localparam int NDiv = QuoW;

    logic [LenW-1:0] mr_reg;
    logic            en;

    logic [M2W-1:0]  m2x, m2y, m2z, m2;
    axis_t           axis;
    item_t           front_next;
    item_t           front_reg;
    logic            front_v_reg;

    logic            sq_v   [NSq+1];
    item_t           sq_it  [NSq+1];
    logic            dv_v   [NDiv+1];
    item_t           dv_it  [NDiv+1];

    item_t                    mid_next;
    item_t                    mid_reg;
    logic                     mid_v_reg;
    logic signed [CoordW:0]   rel;
    logic signed [CoordW+1:0] drel;

    item_t                    fin;
    logic [QuoW-1:0]          off;
    logic [QuoW-1:0]          off2;
    logic signed [CoordW+2:0] res;
    logic signed [CoordW-1:0] coord;
    split_case_t              cs;
    logic signed [LimW:0]     lim_s;

    logic                     out_v_reg;
    logic [OutW-1:0]          out_data_reg;

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mr_reg <= LenW'(65536);
        else if (cfg_we)
            mr_reg <= cfg_wdata;
    end

    // front: axis choice, field select, too-small test, MR*edge, root operand
    always_comb
    begin
        m2x = s_tdata[285 +: M2W];
        m2y = s_tdata[317 +: M2W];
        m2z = s_tdata[349 +: M2W];
        if (m2x > m2y && m2x > m2z)
            axis = AXIS_X;
        else if (m2y > m2z)
            axis = AXIS_Y;
        else
            axis = AXIS_Z;

        front_next = '0;
        front_next.axis = axis;
        case (axis)
            AXIS_X:
            begin
                m2 = m2x;
                front_next.d0  = s_tdata[0 +: CoordW];
                front_next.d10 = s_tdata[96 +: LenW];
                front_next.dp  = s_tdata[189 +: CoordW];
            end
            AXIS_Y:
            begin
                m2 = m2y;
                front_next.d0  = s_tdata[32 +: CoordW];
                front_next.d10 = s_tdata[127 +: LenW];
                front_next.dp  = s_tdata[221 +: CoordW];
            end
            default:
            begin
                m2 = m2z;
                front_next.d0  = s_tdata[64 +: CoordW];
                front_next.d10 = s_tdata[158 +: LenW];
                front_next.dp  = s_tdata[253 +: CoordW];
            end
        endcase
        front_next.too_small = (front_next.d10 <= mr_reg);
        front_next.lim       = LimW'(front_next.d10) * LimW'(mr_reg);
        front_next.sq_v      = {m2, 16'h0000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_v_reg <= 1'b0;
        else if (en)
            front_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            front_reg <= front_next;
    end

    assign sq_v[0]  = front_v_reg;
    assign sq_it[0] = front_reg;

    for (genvar i = 0; i < NSq; i++)
    begin : g_sq
        kdsm_sqrt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_v[i]),
            .in_item   (sq_it[i]),
            .out_valid (sq_v[i+1]),
            .out_item  (sq_it[i+1])
        );
    end

    // products against len, divider set-up
    always_comb
    begin
        mid_next = sq_it[NSq];
        rel  = (CoordW+1)'(sq_it[NSq].dp) - (CoordW+1)'(sq_it[NSq].d0);
        drel = $signed({3'b000, sq_it[NSq].d10}) - (CoordW+2)'(rel);
        mid_next.p_lo   = LoW'(rel) * $signed({{(LoW-RootW){1'b0}}, sq_it[NSq].len});
        mid_next.p_hi   = HiW'(drel) * $signed({{(HiW-RootW){1'b0}}, sq_it[NSq].len});
        mid_next.dv_rem = sq_it[NSq].lim[QuoW +: RootW];
        mid_next.dv_dd  = sq_it[NSq].lim[QuoW-1:0];
        mid_next.quo    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_v_reg <= 1'b0;
        else if (en)
            mid_v_reg <= sq_v[NSq];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            mid_reg <= mid_next;
    end

    assign dv_v[0]  = mid_v_reg;
    assign dv_it[0] = mid_reg;

    for (genvar j = 0; j < NDiv; j++)
    begin : g_div
        kdsm_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_v[j]),
            .in_item   (dv_it[j]),
            .out_valid (dv_v[j+1]),
            .out_item  (dv_it[j+1])
        );
    end

    // case select, sum and saturate
    always_comb
    begin
        fin   = dv_it[NDiv];
        off   = (fin.len == '0) ? '0 : fin.quo;
        off2  = {1'b0, off[QuoW-1:1]};
        lim_s = $signed({1'b0, fin.lim});
        if (({8'h00, fin.len} < {mr_reg, 1'b0}) || fin.d10 == '0)
        begin
            cs  = CASE_HALF;
            res = (CoordW+3)'(fin.d0) + $signed({4'b0000, fin.d10[LenW-1:1]});
        end
        else if (fin.p_lo <= lim_s)
        begin
            cs  = CASE_LOW;
            res = (CoordW+3)'(fin.d0) + $signed({4'b0000, off});
        end
        else if (fin.p_hi <= lim_s)
        begin
            cs  = CASE_HIGH;
            res = (CoordW+3)'(fin.d0) + $signed({4'b0000, fin.d10})
                - $signed({4'b0000, off});
        end
        else if ($signed({(CoordW+1)'(fin.dp) - (CoordW+1)'(fin.d0), 1'b0})
                 < $signed({3'b000, fin.d10}))
        begin
            cs  = CASE_AFTER;
            res = (CoordW+3)'(fin.dp) + $signed({4'b0000, off2});
        end
        else
        begin
            cs  = CASE_BEFORE;
            res = (CoordW+3)'(fin.dp) - $signed({4'b0000, off2});
        end

        if (res > $signed((CoordW+3)'(32'h7FFF_FFFF)))
            coord = 32'sh7FFF_FFFF;
        else if (res < -$signed((CoordW+3)'(33'h0_8000_0000)))
            coord = 32'sh8000_0000;
        else
            coord = res[CoordW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= dv_v[NDiv];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= {2'b00, fin.too_small, cs, coord, fin.axis};
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

    a_axis_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("invalid split axis");

    a_case_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[36:34] <= CASE_BEFORE))
        else $error("invalid split case");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && !$past(s_tready)))
        else $error("pipeline moved while output stalled");

endmodule

// ===== rtl/core/kdsm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// kdsm_sqrt_cell
// One bit of the integer square root of the metric length.
// ----------------------------------------------------------------------------
module kdsm_sqrt_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  kdsm_pkg::item_t in_item,
    output logic           out_valid,
    output kdsm_pkg::item_t out_item
);
    import kdsm_pkg::*;

    logic                valid_reg;
    item_t               item_reg;
    item_t               item_next;
    logic [SqRemW+1:0]   rem_sh;
    logic [SqRemW+1:0]   trial;
    logic                ge;

    always_comb
    begin
        item_next = in_item;
        rem_sh    = {in_item.sq_rem, in_item.sq_v[SqInW-1 -: 2]};
        trial     = {2'b00, in_item.len, 2'b01};
        ge        = (rem_sh >= trial);
        item_next.sq_rem = ge ? SqRemW'(rem_sh - trial) : SqRemW'(rem_sh);
        item_next.len    = {in_item.len[RootW-2:0], ge};
        item_next.sq_v   = {in_item.sq_v[SqInW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/core/kdsm_div_cell.sv =====
// ----------------------------------------------------------------------------
// kdsm_div_cell
// One quotient bit of the restoring divide MR*edge / len.
// ----------------------------------------------------------------------------
module kdsm_div_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  kdsm_pkg::item_t in_item,
    output logic           out_valid,
    output kdsm_pkg::item_t out_item
);
    import kdsm_pkg::*;

    logic            valid_reg;
    item_t           item_reg;
    item_t           item_next;
    logic [RootW:0]  t;
    logic            ge;

    always_comb
    begin
        item_next = in_item;
        t         = {in_item.dv_rem, in_item.dv_dd[QuoW-1]};
        ge        = (t >= {1'b0, in_item.len});
        item_next.dv_rem = ge ? RootW'(t - {1'b0, in_item.len}) : t[RootW-1:0];
        item_next.dv_dd  = {in_item.dv_dd[QuoW-2:0], 1'b0};
        item_next.quo    = {in_item.quo[QuoW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
